// ===== rtl/ita_pkg.sv =====
// Shared types, constants and helper functions for the integer-to-ASCII formatter.
`timescale 1ns / 1ps
package ita_pkg;

	localparam int WORD_W     = 32;
	localparam int HEX_DIGITS = 8;
	localparam int WORD_NIBS  = WORD_W / 4;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_W      = DEC_DIGITS * 4;
	localparam int CHAR_W     = 8;

	// Sequencer counter covers the 32 conversion steps and every hex position.
	localparam int CNT_MAX = (HEX_DIGITS > WORD_W) ? HEX_DIGITS : WORD_W;
	localparam int CNT_W   = $clog2(CNT_MAX);

	// Left-justify the low HEX_DIGITS nibbles when fewer than a full word is shown.
	localparam int HEX_PRE = (HEX_DIGITS < WORD_NIBS) ? 4 * (WORD_NIBS - HEX_DIGITS) : 0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	localparam logic OP_DEC = 1'b0;
	localparam logic OP_HEX = 1'b1;

	typedef enum logic [2:0] {
		UCMD_HOLD,
		UCMD_LOAD,
		UCMD_DAB,
		UCMD_HEX,
		UCMD_DIG
	} unit_cmd_t;

	localparam logic [CHAR_W-1:0] HEX_GLYPHS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
		return HEX_GLYPHS[nib];
	endfunction

	function automatic logic [CHAR_W-1:0] dec_glyph(input logic [3:0] dig);
		return CHAR_ZERO + {4'b0000, dig};
	endfunction

endpackage

// ===== rtl/ita_req_if.sv =====
// Request channel: format mode and 32-bit word.
`timescale 1ns / 1ps
interface ita_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [ita_pkg::WORD_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== rtl/ita_char_if.sv =====
// Character channel: one ASCII code with an end-of-number mark.
`timescale 1ns / 1ps
interface ita_char_if;
	logic                       valid;
	logic                       ready;
	logic [ita_pkg::CHAR_W-1:0] char_code;
	logic                       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/ita_shift_unit.sv =====
// Shared shift unit: binary word and BCD register, shift-add-3 and digit shifts.
`timescale 1ns / 1ps
module ita_shift_unit (
	input  logic                       clk,
	input  ita_pkg::unit_cmd_t         cmd,
	input  logic [ita_pkg::WORD_W-1:0] load_word,
	output logic [3:0]                 top_nib,
	output logic [3:0]                 top_dig
);
	import ita_pkg::*;

	logic [WORD_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;

	// Add three to every digit of five or more before the doubling shift.
	always_comb begin
		for (int d = 0; d < DEC_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			UCMD_LOAD: begin
				bin_q <= load_word;
				bcd_q <= '0;
			end
			UCMD_DAB: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[WORD_W-1]};
				bin_q <= {bin_q[WORD_W-2:0], 1'b0};
			end
			UCMD_HEX: begin
				bin_q <= {bin_q[WORD_W-5:0], 4'b0000};
			end
			UCMD_DIG: begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
			end
			default: begin
			end
		endcase
	end

	assign top_nib = bin_q[WORD_W-1 -: 4];
	assign top_dig = bcd_q[BCD_W-1 -: 4];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level: sequencer around the shared shift unit and the character output register.
//
//  channel | dir | payload                         | request accepted when
//  req     | in  | op (1), value (32)              | req.valid && req.ready
//  chr     | out | char_code (8), last_char (1)    | chr.valid && chr.ready
//
// Hex mode: the word is loaded, then one character per digit (HEX_DIGITS characters).
// Decimal mode: the magnitude is loaded, 32 shift-add-3 steps run in the shift unit, a
// minus sign goes out if negative, then the BCD digits (10), leading zeros dropped.
// req.ready is high only while the sequencer is idle; a stalled chr holds the sign and digit output.
// Reset clears the sequencer and the output valid; no clearing pass.
`timescale 1ns / 1ps
module integer_to_ascii_formatter (
	input  logic       clk,
	input  logic       arst_n,
	ita_req_if.sink    req,
	ita_char_if.source chr
);
	import ita_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_DEC,
		S_HEX
	} state_t;

	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(WORD_W - 1);
	localparam logic [CNT_W-1:0] DEC_LAST  = CNT_W'(DEC_DIGITS - 1);
	localparam logic [CNT_W-1:0] HEX_LAST  = CNT_W'(HEX_DIGITS - 1);
	localparam logic [CNT_W-1:0] WORD_NIB_CNT = CNT_W'(WORD_NIBS);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               lead_q;
	logic               ovalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	unit_cmd_t          cmd;
	logic [WORD_W-1:0]  load_word;
	logic [3:0]         top_nib;
	logic [3:0]         top_dig;
	logic               out_free;
	logic               accept;
	logic               in_word;
	logic               skip_zero;
	logic               load_out;

	assign accept    = req.valid && req.ready;
	assign out_free  = !ovalid_q || chr.ready;
	assign in_word   = cnt_q < WORD_NIB_CNT;
	assign skip_zero = lead_q && (top_dig == 4'd0) && (cnt_q != '0);
	// load a new character into the output register this cycle
	assign load_out  = out_free && ((state_q == S_SIGN) || (state_q == S_HEX) ||
		(state_q == S_DEC && !skip_zero));

	always_comb begin
		if (req.op == OP_HEX) begin
			load_word = req.value << HEX_PRE;
		end else if (req.value[WORD_W-1]) begin
			load_word = '0 - req.value;
		end else begin
			load_word = req.value;
		end
	end

	always_comb begin
		cmd = UCMD_HOLD;
		case (state_q)
			S_IDLE: begin
				if (accept) cmd = UCMD_LOAD;
			end
			S_CONV: cmd = UCMD_DAB;
			S_DEC: begin
				if (skip_zero || out_free) cmd = UCMD_DIG;
			end
			S_HEX: begin
				if (out_free && in_word) cmd = UCMD_HEX;
			end
			default: cmd = UCMD_HOLD;
		endcase
	end

	ita_shift_unit u_shift (
		.clk       (clk),
		.cmd       (cmd),
		.load_word (load_word),
		.top_nib   (top_nib),
		.top_dig   (top_dig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			lead_q   <= 1'b0;
			ovalid_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (chr.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q <= (req.op == OP_DEC) && req.value[WORD_W-1];
						if (req.op == OP_HEX) begin
							cnt_q   <= HEX_LAST;
							state_q <= S_HEX;
						end else begin
							cnt_q   <= CONV_LAST;
							state_q <= S_CONV;
						end
					end
				end
				S_CONV: begin
					if (cnt_q == '0) begin
						cnt_q   <= DEC_LAST;
						lead_q  <= 1'b1;
						state_q <= neg_q ? S_SIGN : S_DEC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						char_q   <= CHAR_MINUS;
						last_q   <= 1'b0;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					if (skip_zero) begin
						// drop a leading zero without using the output slot
						cnt_q <= cnt_q - 1'b1;
					end else if (out_free) begin
						char_q   <= dec_glyph(top_dig);
						last_q   <= (cnt_q == '0);
						lead_q   <= 1'b0;
						if (cnt_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				S_HEX: begin
					if (out_free) begin
						char_q   <= hex_glyph(in_word ? top_nib : 4'd0);
						last_q   <= (cnt_q == '0);
						if (cnt_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign chr.valid     = ovalid_q;
	assign chr.char_code = char_q;
	assign chr.last_char = last_q;

	a_hex_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_HEX) |=> (state_q == S_HEX))
		else $error("hex request did not start digit output");

	a_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && cnt_q == '0) |=> (state_q == S_SIGN || state_q == S_DEC))
		else $error("conversion did not hand over to digit output");

	a_sign_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN && out_free) |=>
			(chr.valid && chr.char_code == CHAR_MINUS && !chr.last_char))
		else $error("minus sign not loaded into output register");

	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(chr.valid && chr.last_char) |-> (chr.char_code != CHAR_MINUS))
		else $error("minus sign marked as last character");

endmodule

// ===== test/testbench.sv =====
// Testbench for the integer-to-ASCII formatter: directed and random numbers checked per character.
`timescale 1ns / 1ps
module testbench;
	import ita_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              is_last;
	} text_char_t;

	logic clk;
	logic arst_n;

	ita_req_if  req_if ();
	ita_char_if chr_if ();

	integer_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.chr    (chr_if)
	);

	text_char_t expected_text [$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected characters of one number, appended to the text queue.
	function automatic void predict_text(input logic op, input logic [WORD_W-1:0] value);
		logic [3:0]        nib;
		logic [WORD_W-1:0] mag;
		logic [3:0]        digit_stack [$];
		if (op == OP_HEX) begin
			for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
				nib = (i < WORD_NIBS) ? value[4*i +: 4] : 4'd0;
				expected_text.push_back(text_char_t'{
					code:    (nib < 4'd10) ? CHAR_ZERO + {4'b0000, nib}
						: 8'("A") + {4'b0000, nib} - 8'd10,
					is_last: (i == 0)});
			end
		end else if (value == '0) begin
			expected_text.push_back(text_char_t'{code: CHAR_ZERO, is_last: 1'b1});
		end else begin
			mag = value[WORD_W-1] ? ('0 - value) : value;
			if (value[WORD_W-1])
				expected_text.push_back(text_char_t'{code: CHAR_MINUS, is_last: 1'b0});
			while (mag != '0) begin
				digit_stack.push_front(4'(mag % 10));
				mag = mag / 10;
			end
			foreach (digit_stack[k])
				expected_text.push_back(text_char_t'{
					code:    CHAR_ZERO + {4'b0000, digit_stack[k]},
					is_last: (k == digit_stack.size() - 1)});
		end
	endfunction

	// Predict on each accepted request, then check each accepted character.
	always @(posedge clk) begin : track_text
		text_char_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				predict_text(req_if.op, req_if.value);
			if (chr_if.valid && chr_if.ready) begin
				if (expected_text.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("unexpected char: code=%h last=%b",
							chr_if.char_code, chr_if.last_char);
					error_count++;
				end else begin
					want = expected_text.pop_front();
					if (chr_if.char_code !== want.code || chr_if.last_char !== want.is_last) begin
						if (error_count < MAX_REPORTS)
							$display("char mismatch: expected code=%h last=%b, got code=%h last=%b",
								want.code, want.is_last, chr_if.char_code, chr_if.last_char);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk)
		chr_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one request after a random idle gap; leave valid high on return.
	task automatic send_number(input logic op, input logic [WORD_W-1:0] value);
		int gap;
		gap = 0;
		while (gap < 400 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.value <= value;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	// Drop valid and wait until every predicted character has come out.
	task automatic drain_text();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_value();
		logic [WORD_W-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(0, 999);
			2: v = '0 - WORD_W'($urandom_range(1, 1000));
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(1))
					v = '0 - v;
			end
		endcase
		return v;
	endfunction

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_number($urandom_range(1) ? OP_HEX : OP_DEC, pick_value());
		drain_text();
	endtask

	task automatic test_directed();
		logic [WORD_W-1:0] corner [10];
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0001, 32'd9, 32'd10, 32'd1000000000, 32'h0123_4567, 32'h89AB_CDEF};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (corner[i]) begin
			send_number(OP_DEC, corner[i]);
			send_number(OP_HEX, corner[i]);
		end
		send_number(OP_DEC, 32'd999999999);
		send_number(OP_DEC, '0 - 32'd10);
		send_number(OP_DEC, 32'd1);
		drain_text();
	endtask

	task automatic test_random_no_idle();
		run_random(30, 0, 0);
	endtask

	task automatic test_random_sender_idle();
		run_random(25, 88, 0);
	endtask

	task automatic test_random_receiver_stall();
		run_random(25, 0, 88);
	endtask

	task automatic test_random_both_idle();
		run_random(27, 33, 33);
	endtask

	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.op    = OP_DEC;
		req_if.value = '0;
		chr_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_text.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== integer_to_ascii_formatter.f =====
rtl/ita_pkg.sv
rtl/ita_req_if.sv
rtl/ita_char_if.sv
rtl/ita_shift_unit.sv
rtl/integer_to_ascii_formatter.sv
test/testbench.sv
